// ===== design/flood_duplicate_filter_core_defines.svh =====
// Assertion macros shared by the flood duplicate filter checker.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef FLOOD_DUPLICATE_FILTER_CORE_DEFINES_SVH
`define FLOOD_DUPLICATE_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FDF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("flood_duplicate_filter_core: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("flood_duplicate_filter_core: next-cycle check failed");

`endif

// ===== design/fdf_pkg.sv =====
// Package of the flood duplicate filter: payload structs, codes, FSM states.
// Used by every module of the block; depends on nothing.
`default_nettype none

package fdf_pkg;

	localparam int SEEN_DEPTH_DEF = 64;
	localparam int SEQ_BITS_DEF   = 16;

	localparam int ID_W    = 6;
	localparam int MASK_W  = 64;
	localparam int SEQ_W   = 16;
	localparam int DATA_W  = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_MASK = 2'd1;

	typedef enum logic [1:0] {
		VERDICT_FORWARD      = 2'd0,
		VERDICT_NOT_NEIGHBOR = 2'd1,
		VERDICT_DUPLICATE    = 2'd2
	} fdf_verdict_t;

	typedef struct packed {
		logic [ID_W-1:0]   sender_id;
		logic [SEQ_W-1:0]  seq_in;
		logic [DATA_W-1:0] payload_in;
	} fdf_in_t;

	typedef struct packed {
		logic [1:0]        verdict;
		logic [ID_W-1:0]   fwd_id;
		logic [SEQ_W-1:0]  fwd_seq;
		logic [DATA_W-1:0] fwd_data;
	} fdf_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_DRAIN
	} fdf_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic         capture;
		logic         scan_clear;
		logic         scan_read;
		logic         record;
		logic         emit;
		fdf_verdict_t verdict;
	} fdf_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic neighbor;
		logic store_empty;
		logic scan_last;
		logic hit_now;
	} fdf_status_t;

endpackage

`default_nettype wire

// ===== design/fdf_datapath.sv =====
// Datapath of the flood duplicate filter: config registers, seen memory,
// scan compare, counters and result register. Depends on fdf_pkg.
`default_nettype none

module fdf_datapath #(
	parameter int SEEN_DEPTH = fdf_pkg::SEEN_DEPTH_DEF,
	parameter int SEQ_BITS   = fdf_pkg::SEQ_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [fdf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [fdf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  wire fdf_pkg::fdf_in_t                  item,
	input  wire fdf_pkg::fdf_cmd_t                 cmd,
	output fdf_pkg::fdf_status_t                   status,
	output logic                                   result_valid,
	output fdf_pkg::fdf_out_t                      result
);

	localparam int AW = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
	localparam int CW = $clog2(SEEN_DEPTH + 1);

	logic [fdf_pkg::ID_W-1:0]   node_id_q;
	logic [fdf_pkg::MASK_W-1:0] neighbor_q;
	fdf_pkg::fdf_in_t           item_q;

	logic [SEQ_BITS-1:0] seen_mem [SEEN_DEPTH];
	logic [SEQ_BITS-1:0] rd_data_s1;
	logic                rd_valid_s1;

	logic [CW-1:0]       fill_q;
	logic [AW-1:0]       slot_q;
	logic [CW-1:0]       idx_q;
	logic                hit_q;
	logic [SEQ_BITS-1:0] own_seq_q;
	logic [SEQ_BITS-1:0] own_seq_next;

	logic [SEQ_BITS+15:0] seq_wide;
	logic [SEQ_BITS-1:0]  seq_cut;
	logic [SEQ_BITS+15:0] own_wide;
	logic                 match;
	logic                 fwd;

	fdf_pkg::fdf_out_t result_q;
	logic              result_valid_q;

	// The received number is cut or zero-extended to the stored width.
	assign seq_wide     = {{SEQ_BITS{1'b0}}, item_q.seq_in};
	assign seq_cut      = seq_wide[SEQ_BITS-1:0];
	assign own_seq_next = own_seq_q + SEQ_BITS'(1);
	assign own_wide     = {16'd0, own_seq_next};
	assign match        = rd_valid_s1 && (rd_data_s1 == seq_cut);
	assign fwd          = (cmd.verdict == fdf_pkg::VERDICT_FORWARD);

	assign status.neighbor    = neighbor_q[item_q.sender_id];
	assign status.store_empty = (fill_q == '0);
	assign status.scan_last   = ((idx_q + CW'(1)) == fill_q);
	assign status.hit_now     = hit_q | match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q  <= '0;
			neighbor_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fdf_pkg::CFG_NODE_ID:       node_id_q  <= cfg_wdata[fdf_pkg::ID_W-1:0];
				fdf_pkg::CFG_NEIGHBOR_MASK: neighbor_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
	end

	// Seen store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.record) begin
			seen_mem[slot_q] <= seq_cut;
		end
		rd_data_s1 <= seen_mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			slot_q      <= '0;
			idx_q       <= '0;
			hit_q       <= 1'b0;
			rd_valid_s1 <= 1'b0;
			own_seq_q   <= '0;
		end else begin
			rd_valid_s1 <= cmd.scan_read;
			if (cmd.scan_clear) begin
				idx_q <= '0;
				hit_q <= 1'b0;
			end else begin
				if (cmd.scan_read) begin
					idx_q <= idx_q + CW'(1);
				end
				hit_q <= hit_q | match;
			end
			if (cmd.record) begin
				slot_q    <= (slot_q == AW'(SEEN_DEPTH - 1)) ? '0 : slot_q + AW'(1);
				own_seq_q <= own_seq_next;
				if (fill_q != CW'(SEEN_DEPTH)) begin
					fill_q <= fill_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.verdict  <= cmd.verdict;
			result_q.fwd_id   <= node_id_q;
			result_q.fwd_seq  <= fwd ? own_wide[15:0] : '0;
			result_q.fwd_data <= fwd ? item_q.payload_in : '0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// ===== design/fdf_ctrl.sv =====
// Controller of the flood duplicate filter: the state machine that sequences
// capture, neighbor check, store scan and decision. Depends on fdf_pkg.
`default_nettype none

module fdf_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire fdf_pkg::fdf_status_t  status,
	output logic                       busy,
	output fdf_pkg::fdf_cmd_t          cmd
);

	fdf_pkg::fdf_state_t state_q;
	fdf_pkg::fdf_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fdf_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		cmd.verdict = fdf_pkg::VERDICT_FORWARD;
		busy       = 1'b1;
		unique case (state_q)
			fdf_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_next  = fdf_pkg::ST_CHECK;
				end
			end
			fdf_pkg::ST_CHECK: begin
				cmd.scan_clear = 1'b1;
				priority if (!status.neighbor) begin
					cmd.emit    = 1'b1;
					cmd.verdict = fdf_pkg::VERDICT_NOT_NEIGHBOR;
					state_next  = fdf_pkg::ST_IDLE;
				end else if (status.store_empty) begin
					cmd.record = 1'b1;
					cmd.emit   = 1'b1;
					state_next = fdf_pkg::ST_IDLE;
				end else begin
					state_next = fdf_pkg::ST_SCAN;
				end
			end
			fdf_pkg::ST_SCAN: begin
				cmd.scan_read = 1'b1;
				if (status.scan_last) begin
					state_next = fdf_pkg::ST_DRAIN;
				end
			end
			fdf_pkg::ST_DRAIN: begin
				cmd.emit   = 1'b1;
				state_next = fdf_pkg::ST_IDLE;
				if (status.hit_now) begin
					cmd.verdict = fdf_pkg::VERDICT_DUPLICATE;
				end else begin
					cmd.record = 1'b1;
				end
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/flood_duplicate_filter_core.sv =====
// Top level of the flood duplicate filter: controller plus datapath.
// Depends on fdf_pkg, fdf_ctrl and fdf_datapath.
//
// Usage: an input packet transfer happens at a rising edge where start is high
// and busy is low; item carries sender id, sequence number and data word.
// Every packet gives exactly one result transfer: result_valid is high for one
// cycle and result holds the verdict (forward, not a neighbor, duplicate), this
// node's id, and for a forward the new own sequence number and the data word.
// The receiver has no way to stall, so each result is shown once and is gone.
// Sequence: a packet from a non-neighbor, or one that meets an empty seen
// store, is decided in the check state and its result registered from there.
// Otherwise the seen memory, which has a single read port, is read one entry
// per cycle over all filled entries, and the decision is made in the drain
// state after the last read. busy falls in the cycle the result is shown, and
// a new start is taken there, so packets never overlap inside the block.
// Configuration (node id at index 0, neighbor mask at index 1) is written
// through cfg_we / cfg_index / cfg_wdata; the user must write it only while
// the block is idle, which the block itself does not enforce. Other indexes
// are ignored. Reset clears the registers, the fill count, the write slot and
// the own sequence counter; the seen memory itself is not cleared, only
// entries below the fill count are ever compared.
`default_nettype none

module flood_duplicate_filter_core #(
	parameter int SEEN_DEPTH = fdf_pkg::SEEN_DEPTH_DEF,
	parameter int SEQ_BITS   = fdf_pkg::SEQ_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [fdf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [fdf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  wire logic                              start,
	input  wire fdf_pkg::fdf_in_t                  item,
	output logic                                   busy,
	output logic                                   result_valid,
	output fdf_pkg::fdf_out_t                      result
);

	// Command and status groups between the controller and the datapath.
	fdf_pkg::fdf_cmd_t    cmd;
	fdf_pkg::fdf_status_t status;

	// The controller decides per state what the datapath does this cycle.
	fdf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	// The datapath owns every register that holds packet or store data.
	fdf_datapath #(
		.SEEN_DEPTH (SEEN_DEPTH),
		.SEQ_BITS   (SEQ_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.item         (item),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

`default_nettype wire

// ===== design/fdf_checker.sv =====
// Port-level checker of the flood duplicate filter, bound to the top level.
// Depends on fdf_pkg and flood_duplicate_filter_core_defines.svh.
`default_nettype none

`include "flood_duplicate_filter_core_defines.svh"

module fdf_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              result_valid,
	input wire fdf_pkg::fdf_out_t result
);

	`FDF_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`FDF_ASSERT_NEXT(a_result_single, clk, arst_n, result_valid, !result_valid)
	`FDF_ASSERT_SAME(a_result_idle, clk, arst_n, result_valid, !busy)
	`FDF_ASSERT_SAME(a_busy_ends_in_result, clk, arst_n, $fell(busy), result_valid)
	`FDF_ASSERT_SAME(a_drop_zero, clk, arst_n,
		result_valid && (result.verdict != fdf_pkg::VERDICT_FORWARD),
		(result.fwd_seq == '0) && (result.fwd_data == '0))

endmodule

bind flood_duplicate_filter_core fdf_checker u_fdf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);

`default_nettype wire

// ===== tb/tb_flood_duplicate_filter_core.sv =====
// Self-checking testbench for flood_duplicate_filter_core: directed and random packets.
// Uses fdf_pkg for the payload structs, register indexes and verdict codes.
`timescale 1ns / 1ps

module tb_flood_duplicate_filter_core;
	import fdf_pkg::*;

	localparam int STORE_DEPTH = SEEN_DEPTH_DEF;
	// The drain wait is longer than the full store scan of the slowest packet.
	localparam int DRAIN_CYCLES = SEEN_DEPTH_DEF + 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PERCENT = 13;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic start = 1'b0;
	fdf_in_t item = '0;
	logic busy;
	logic result_valid;
	fdf_out_t result;

	flood_duplicate_filter_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.item(item),
		.busy(busy),
		.result_valid(result_valid),
		.result(result)
	);

	always #1 clk = ~clk;

	// Packets waiting to be offered to the block, filled by the sequencer below.
	fdf_in_t rx_packets[$];
	// One predicted outcome per accepted packet, oldest first.
	fdf_out_t predicted_outcomes[$];
	// Sequence numbers already sent, drawn on to build duplicates.
	logic [SEQ_W-1:0] sent_seqs[$];

	// Sender-side controls set by the sequencer.
	logic quiet = 1'b0;
	logic hold_sender = 1'b0;

	int fail_count = 0;
	int cycle_count = 0;

	// Shadow copy of the filter's registers and state.
	logic [ID_W-1:0] node_cfg;
	logic [MASK_W-1:0] neighbor_cfg;
	logic [SEQ_W-1:0] seen_seq[STORE_DEPTH];
	int seen_count;
	int next_slot;
	logic [SEQ_W-1:0] relay_seq;

	// Works out the verdict for one received packet and advances the shadow state.
	// A neighbor's packet with a sequence number not among the filled entries
	// is recorded (overwriting the oldest entry once the store is full) and
	// forwarded under a freshly incremented own sequence number.
	function automatic fdf_out_t filter_packet(fdf_in_t pkt);
		fdf_out_t res;
		logic hit;
		res = '0;
		hit = 1'b0;
		res.fwd_id = node_cfg;
		if (!neighbor_cfg[pkt.sender_id]) begin
			res.verdict = VERDICT_NOT_NEIGHBOR;
		end else begin
			for (int i = 0; i < seen_count; i++) begin
				if (seen_seq[i] == pkt.seq_in)
					hit = 1'b1;
			end
			if (hit) begin
				res.verdict = VERDICT_DUPLICATE;
			end else begin
				seen_seq[next_slot] = pkt.seq_in;
				next_slot = (next_slot + 1) % STORE_DEPTH;
				if (seen_count < STORE_DEPTH)
					seen_count++;
				// The counter is as wide as the field, so it wraps by itself.
				relay_seq = relay_seq + 1'b1;
				res.verdict = VERDICT_FORWARD;
				res.fwd_seq = relay_seq;
				res.fwd_data = pkt.payload_in;
			end
		end
		return res;
	endfunction

	// Driver. A packet is moved on the edge where start is high and busy is low;
	// while busy is high the offered packet is held unchanged. The next value
	// of start and item is settled first and then assigned once per edge.
	always @(posedge clk) begin : drive_proc
		fdf_in_t next_pkt;
		logic next_start;
		if (arst_n && start && !busy)
			predicted_outcomes.push_back(filter_packet(item));
		next_start = start && busy;
		next_pkt = item;
		if (!next_start && arst_n && !hold_sender && rx_packets.size() != 0 &&
				(quiet || $urandom_range(99) >= IDLE_PERCENT)) begin
			next_pkt = rx_packets.pop_front();
			next_start = 1'b1;
		end
		start <= next_start;
		item <= next_pkt;
	end

	// Monitor. A result is shown for one cycle only and cannot be stalled, so
	// every strobe is taken as a transfer and matched against the oldest
	// prediction.
	always @(posedge clk) begin : check_proc
		fdf_out_t want;
		if (arst_n && result_valid) begin
			if (predicted_outcomes.size() == 0) begin
				$error("result transfer with nothing outstanding: verdict %0d", result.verdict);
				fail_count++;
			end else begin
				want = predicted_outcomes.pop_front();
				if (result.verdict !== want.verdict) begin
					$error("verdict: expected %0d, actual %0d", want.verdict, result.verdict);
					fail_count++;
				end
				if (result.fwd_id !== want.fwd_id) begin
					$error("fwd_id: expected %0d, actual %0d", want.fwd_id, result.fwd_id);
					fail_count++;
				end
				if (result.fwd_seq !== want.fwd_seq) begin
					$error("fwd_seq: expected %0d, actual %0d", want.fwd_seq, result.fwd_seq);
					fail_count++;
				end
				if (result.fwd_data !== want.fwd_data) begin
					$error("fwd_data: expected %h, actual %h", want.fwd_data, result.fwd_data);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic queue_packet(input logic [ID_W-1:0] sender, input logic [SEQ_W-1:0] seq,
			input logic [DATA_W-1:0] data);
		fdf_in_t pkt;
		pkt.sender_id = sender;
		pkt.seq_in = seq;
		pkt.payload_in = data;
		rx_packets.push_back(pkt);
		sent_seqs.push_back(seq);
	endtask

	// Waits until the block has nothing in flight and the sender has nothing queued.
	// The state is looked at on the falling edge, once the driver's updates
	// of the rising edge have settled.
	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (rx_packets.size() != 0 || start || busy || predicted_outcomes.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Writes one register; the shadow copy follows, and indexes above the
	// neighbor mask are ignored by the block.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx == CFG_NODE_ID)
			node_cfg = val[ID_W-1:0];
		else if (idx == CFG_NEIGHBOR_MASK)
			neighbor_cfg = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [ID_W-1:0] pick_neighbor();
		logic [ID_W-1:0] k;
		do
			k = ID_W'($urandom_range(63));
		while (!neighbor_cfg[k]);
		return k;
	endfunction

	// Random packets. Most come from neighbors, and about two in five of those
	// repeat a recent sequence number, so duplicates, store wrap-around and the
	// return of evicted numbers all happen. The rest is noise from any sender.
	task automatic queue_random(input int count);
		int r;
		int lo;
		logic [ID_W-1:0] sender;
		logic [SEQ_W-1:0] seq;
		repeat (count) begin
			r = $urandom_range(99);
			if (r < 15 || neighbor_cfg == '0)
				sender = ID_W'($urandom_range(63));
			else
				sender = pick_neighbor();
			if (r >= 15 && r < 50 && sent_seqs.size() != 0) begin
				lo = (sent_seqs.size() > 80) ? sent_seqs.size() - 80 : 0;
				seq = sent_seqs[$urandom_range(sent_seqs.size() - 1, lo)];
			end else begin
				seq = SEQ_W'($urandom);
			end
			queue_packet(sender, seq, DATA_W'($urandom));
		end
	endtask

	initial begin
		node_cfg = '0;
		neighbor_cfg = '0;
		seen_count = 0;
		next_slot = 0;
		relay_seq = '0;
		foreach (seen_seq[i])
			seen_seq[i] = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers at their reset values: nobody is a neighbor.
		queue_packet(6'd0, 16'h0000, 32'h0000_0000);
		queue_packet(6'd63, 16'hFFFF, 32'hFFFF_FFFF);
		wait_idle();

		// Every sender is a neighbor; writes to the unused indexes must not
		// touch either register.
		write_reg(CFG_NODE_ID, 64'd63);
		write_reg(CFG_NEIGHBOR_MASK, '1);
		write_reg(2'd2, '0);
		write_reg(2'd3, '1);
		queue_packet(6'd0, 16'h0000, 32'h0000_0000);   // empty store, forwarded
		queue_packet(6'd63, 16'hFFFF, 32'hFFFF_FFFF);  // own id as sender
		queue_packet(6'd10, 16'h0000, 32'h5A5A_5A5A);  // duplicate
		queue_packet(6'd63, 16'hFFFF, 32'h1234_5678);  // duplicate at the top value
		queue_packet(6'd1, 16'h0001, 32'hA5A5_A5A5);
		wait_idle();

		// Only the two outermost ids are neighbors.
		write_reg(CFG_NODE_ID, 64'd0);
		write_reg(CFG_NEIGHBOR_MASK, 64'h8000_0000_0000_0001);
		queue_packet(6'd0, 16'h0002, 32'h0F0F_0F0F);   // own id, bit set
		queue_packet(6'd1, 16'h0003, 32'hF0F0_F0F0);
		queue_packet(6'd63, 16'h0001, 32'h0000_0001);  // duplicate
		queue_packet(6'd62, 16'h0004, 32'h8000_0000);
		queue_packet(6'd63, 16'h0004, 32'h7FFF_FFFF);
		wait_idle();

		// This node's own bit cleared: its own id is not accepted.
		write_reg(CFG_NODE_ID, 64'd5);
		write_reg(CFG_NEIGHBOR_MASK, ~(64'd1 << 5));
		queue_packet(6'd5, 16'h0007, 32'hDEAD_BEEF);
		queue_packet(6'd4, 16'h0007, 32'hCAFE_F00D);
		queue_packet(6'd6, 16'h0007, 32'h0BAD_F00D);   // duplicate
		wait_idle();

		// Random settings of both registers.
		write_reg(CFG_NODE_ID, 64'($urandom_range(63)));
		write_reg(CFG_NEIGHBOR_MASK, {$urandom, $urandom});
		queue_random(120);
		wait_idle();

		// Back-to-back packets with no gaps from the sender.
		quiet = 1'b1;
		write_reg(CFG_NODE_ID, 64'd0);
		write_reg(CFG_NEIGHBOR_MASK, '1);
		queue_random(120);
		wait_idle();
		quiet = 1'b0;

		// Sparse neighbor set; halfway the sender holds off until the block
		// has returned every outstanding result.
		write_reg(CFG_NODE_ID, 64'd63);
		write_reg(CFG_NEIGHBOR_MASK, 64'h8000_0100_0002_0001);
		queue_random(110);
		while (rx_packets.size() > 55)
			@(posedge clk);
		hold_sender = 1'b1;
		do begin
			@(negedge clk);
		end while (start || busy || predicted_outcomes.size() != 0);
		hold_sender = 1'b0;
		wait_idle();

		write_reg(CFG_NODE_ID, 64'($urandom_range(63)));
		write_reg(CFG_NEIGHBOR_MASK, {$urandom, $urandom} | 64'h1);
		queue_random(100);
		wait_idle();

		// Catch any stray result after the last expected one.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
